>>> rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer package
// Shared token kinds, lexer modes, widths and the queue entry type.
// ----------------------------------------------------------------------------
package sbt_pkg;

   localparam int unsigned BufferBytes = 1048576;
   localparam int unsigned PosW        = 21;
   localparam int unsigned StartW      = 20;

   localparam logic [2:0] KIND_INT     = 3'd0;
   localparam logic [2:0] KIND_FLOAT   = 3'd1;
   localparam logic [2:0] KIND_SYMBOL  = 3'd2;
   localparam logic [2:0] KIND_DELIM   = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_UNTERM  = 3'd5;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_NUM     = 3'd1;
   localparam logic [2:0] MODE_SYM     = 3'd2;
   localparam logic [2:0] MODE_QUOTE   = 3'd3;
   localparam logic [2:0] MODE_SLASH   = 3'd4;
   localparam logic [2:0] MODE_COMMENT = 3'd5;

   typedef struct packed {
      logic [2:0]        kind;
      logic [StartW-1:0] start;
      logic [PosW-1:0]   length;
      logic [31:0]       ival;
      logic [7:0]        delim;
      logic              last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  t0;
      token_type  t1;
      token_type  t2;
   } group_type;

endpackage

>>> rtl/sbt_front.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer front end
// Accepts bytes, runs the lexer state and builds the group of up to three
// tokens that each byte causes.
// ----------------------------------------------------------------------------
module sbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                req_final_byte,
   output logic                grp_valid,
   output sbt_pkg::group_type  grp_data,
   input  logic                grp_full
);
   import sbt_pkg::*;

   logic [2:0]        mode_ff, mode_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [StartW-1:0] start_ff, start_in;
   logic [PosW-1:0]   len_ff, len_in;
   logic [31:0]       acc_ff, acc_in;
   logic              neg_ff, neg_in, stop_ff, stop_in, point_ff, point_in;
   logic              take;
   token_type         tk [3];
   logic [1:0]        n;
   logic [7:0]        c;

   assign req_stall = grp_full;
   assign take      = req_valid && !grp_full;
   assign c         = req_byte_in;

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction
   function automatic logic is_num(input logic [7:0] b);
      return is_digit(b) || b == 8'h2E || b == 8'h2B || b == 8'h2D;
   endfunction
   function automatic logic is_sym(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
   endfunction
   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
   endfunction

   always_comb begin
      logic [2:0]        m;
      logic [StartW-1:0] st;
      logic [PosW-1:0]   ln;
      logic [31:0]       ac;
      logic              ng, sp, pt, fin_run, begin_tok;
      logic [PosW-1:0]   pos_now;
      token_type         e;
      m  = mode_ff;
      st = start_ff;
      ln = len_ff;
      ac = acc_ff;
      ng = neg_ff;
      sp = stop_ff;
      pt = point_ff;
      n  = 2'd0;
      e  = '0;
      tk[0] = '0;
      tk[1] = '0;
      tk[2] = '0;
      fin_run   = 1'b0;
      begin_tok = 1'b0;
      pos_now   = pos_ff;
      if (pos_ff < PosW'(BufferBytes)) begin
         unique case (mode_ff)
            MODE_NUM: begin
               if (is_num(c)) begin
                  if (c == 8'h2E) begin
                     pt = 1'b1;
                     sp = 1'b1;
                  end else if (c == 8'h2B || c == 8'h2D) begin
                     sp = 1'b1;
                  end else if (!sp) begin
                     ac = 32'(ac * 32'd10) + {24'd0, c - 8'h30};
                  end
                  ln = ln + 1'b1;
               end else begin
                  fin_run   = 1'b1;
                  begin_tok = 1'b1;
               end
            end
            MODE_SYM: begin
               if (is_sym(c)) begin
                  ln = ln + 1'b1;
               end else begin
                  fin_run   = 1'b1;
                  begin_tok = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (c == 8'h22) begin
                  e.kind   = KIND_SYMBOL;
                  e.start  = st;
                  e.length = ln;
                  tk[n]    = e;
                  n        = n + 1'b1;
                  m        = MODE_IDLE;
               end else begin
                  ln = ln + 1'b1;
               end
            end
            MODE_SLASH: begin
               if (c == 8'h2F) begin
                  m = MODE_COMMENT;
               end else begin
                  fin_run   = 1'b1;
                  begin_tok = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == 8'h0D || c == 8'h0A) begin
                  m = MODE_IDLE;
               end
            end
            default: begin
               begin_tok = 1'b1;
            end
         endcase
         if (fin_run) begin
            e = '0;
            e.start  = st;
            e.length = ln;
            if (mode_ff == MODE_NUM) begin
               e.kind = pt ? KIND_FLOAT : KIND_INT;
               e.ival = pt ? 32'd0 : (ng ? 32'd0 - ac : ac);
            end else if (mode_ff == MODE_SLASH) begin
               e.kind   = KIND_DELIM;
               e.length = PosW'(1);
               e.delim  = 8'h2F;
            end else begin
               e.kind = KIND_SYMBOL;
            end
            tk[n] = e;
            n     = n + 1'b1;
         end
         if (begin_tok) begin
            m = MODE_IDLE;
            if (is_space(c)) begin
               m = MODE_IDLE;
            end else if (c == 8'h2F) begin
               m  = MODE_SLASH;
               st = pos_ff[StartW-1:0];
            end else if (is_num(c)) begin
               m  = MODE_NUM;
               st = pos_ff[StartW-1:0];
               ac = is_digit(c) ? {24'd0, c - 8'h30} : 32'd0;
               ng = (c == 8'h2D);
               pt = (c == 8'h2E);
               sp = (c == 8'h2E);
               ln = PosW'(1);
            end else if (is_sym(c)) begin
               m  = MODE_SYM;
               st = pos_ff[StartW-1:0];
               ln = PosW'(1);
            end else if (c == 8'h22) begin
               m  = MODE_QUOTE;
               st = StartW'(pos_ff + 1'b1);
               ln = '0;
            end else begin
               e = '0;
               e.kind   = KIND_DELIM;
               e.start  = pos_ff[StartW-1:0];
               e.length = PosW'(1);
               e.delim  = c;
               tk[n]    = e;
               n        = n + 1'b1;
            end
         end
         pos_now = pos_ff + 1'b1;
      end
      pos_in = pos_now;
      if (req_final_byte) begin
         e = '0;
         e.start  = st;
         e.length = ln;
         if (m == MODE_NUM) begin
            e.kind = pt ? KIND_FLOAT : KIND_INT;
            e.ival = pt ? 32'd0 : (ng ? 32'd0 - ac : ac);
         end else if (m == MODE_SYM) begin
            e.kind = KIND_SYMBOL;
         end else if (m == MODE_QUOTE) begin
            e.kind = KIND_UNTERM;
         end else begin
            e.kind   = KIND_DELIM;
            e.length = PosW'(1);
            e.delim  = 8'h2F;
         end
         if (m == MODE_NUM || m == MODE_SYM || m == MODE_QUOTE || m == MODE_SLASH) begin
            tk[n] = e;
            n     = n + 1'b1;
         end
         e = '0;
         e.kind   = KIND_END;
         e.length = pos_now;
         tk[n]    = e;
         n        = n + 1'b1;
         m  = MODE_IDLE;
         pos_in = '0;
         st = '0;
         ln = '0;
         ac = '0;
         ng = 1'b0;
         sp = 1'b0;
         pt = 1'b0;
      end
      if (n != 2'd0) begin
         tk[n - 1'b1].last = 1'b1;
      end
      mode_in  = m;
      start_in = st;
      len_in   = ln;
      acc_in   = ac;
      neg_in   = ng;
      stop_in  = sp;
      point_in = pt;
   end

   assign grp_valid      = take && (n != 2'd0);
   assign grp_data.count = n;
   assign grp_data.t0    = tk[0];
   assign grp_data.t1    = tk[1];
   assign grp_data.t2    = tk[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         point_ff <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         stop_ff  <= stop_in;
         point_ff <= point_in;
      end
   end

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff != 3'd6 && mode_ff != 3'd7) else $error("illegal lexer mode");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      take && req_final_byte |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("final byte did not clear the lexer");
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      take && req_final_byte |-> grp_valid) else $error("final byte gave no end token");

endmodule

>>> rtl/sbt_back.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer back end
// Holds a two-entry queue of token groups and sends their tokens one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module sbt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   input  sbt_pkg::group_type grp_data,
   output logic               grp_full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_kind,
   output logic [19:0]        rsp_token_start,
   output logic [20:0]        rsp_token_length,
   output logic [31:0]        rsp_int_value,
   output logic [7:0]         rsp_delim_char,
   output logic               rsp_run_end
);
   import sbt_pkg::*;

   group_type  q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       pop, push;
   token_type  cur;
   group_type  head;

   assign head      = q_ff[rp_ff];
   assign rsp_valid = cnt_ff != 2'd0;
   assign grp_full  = cnt_ff == 2'd2;
   assign push      = grp_valid;

   always_comb begin
      case (idx_ff)
         2'd0:    cur = head.t0;
         2'd1:    cur = head.t1;
         default: cur = head.t2;
      endcase
   end

   assign pop = rsp_valid && !rsp_stall && (idx_ff + 1'b1 == head.count);

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && !rsp_stall) begin
         idx_in = pop ? 2'd0 : idx_ff + 1'b1;
      end
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rsp_token_kind   = cur.kind;
   assign rsp_token_start  = cur.start;
   assign rsp_token_length = cur.length;
   assign rsp_int_value    = cur.ival;
   assign rsp_delim_char   = cur.delim;
   assign rsp_run_end      = cur.last;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= grp_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && grp_full)) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff < head.count) else $error("token index beyond group");

endmodule

>>> rtl/script_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer
// Turns a byte stream of script text into number, symbol and delimiter tokens.
// ----------------------------------------------------------------------------
// One script byte arrives per item on the req_ channel, with req_final_byte
// set on the last byte of a buffer. Each byte yields zero to three token items
// on the rsp_ channel; rsp_run_end marks the last token of a byte, and the
// final byte always adds an end token whose length is the byte count.
// The front end takes one byte per cycle while req_stall is low and
// classifies it in that same cycle; its token group goes into a two-entry
// queue. The back end sends one token per cycle while rsp_stall is low, from
// the registered queue entry. Bytes keep that rate while each makes at most
// one token; a byte with several tokens holds the output until all are sent.
// When the receiver stalls, the queue fills and req_stall rises; the held token
// stays on the rsp_ ports. Reset clears the lexer state, byte count and queue.
// ----------------------------------------------------------------------------
module script_byte_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [19:0] rsp_token_start,
   output logic [20:0] rsp_token_length,
   output logic [31:0] rsp_int_value,
   output logic [7:0]  rsp_delim_char,
   output logic        rsp_run_end
);
   import sbt_pkg::*;

   logic      grp_valid, grp_full;
   group_type grp_data;

   sbt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_byte_in, .req_final_byte,
      .grp_valid, .grp_data, .grp_full
   );

   sbt_back u_back (
      .clock, .reset, .grp_valid, .grp_data, .grp_full,
      .rsp_valid, .rsp_stall, .rsp_token_kind, .rsp_token_start,
      .rsp_token_length, .rsp_int_value, .rsp_delim_char, .rsp_run_end
   );

endmodule

>>> test/script_byte_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Script byte tokenizer checker
// Watches both channels, predicts the tokens of every accepted byte and
// compares each accepted token with the oldest predicted one.
// ----------------------------------------------------------------------------
module script_byte_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_final_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_token_kind,
   input  logic [19:0] rsp_token_start,
   input  logic [20:0] rsp_token_length,
   input  logic [31:0] rsp_int_value,
   input  logic [7:0]  rsp_delim_char,
   input  logic        rsp_run_end,
   output int          mismatch_count,
   output int          tokens_pending
);
   import sbt_pkg::*;

   token_type   token_queue[$];
   token_type   byte_tokens[$];
   logic [2:0]  mode;
   logic [31:0] position;
   logic [19:0] tok_start;
   logic [20:0] tok_len;
   logic [31:0] acc;
   logic        neg;
   logic        stopped;
   logic        point;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return is_digit(c) || c == "." || c == "+" || c == "-";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
   endfunction

   task automatic push_token(logic [2:0] k, logic [31:0] s, logic [31:0] l,
                             logic [31:0] v, logic [7:0] d);
      token_type t;
      t.kind = k;
      t.start = s[19:0];
      t.length = l[20:0];
      t.ival = v;
      t.delim = d;
      t.last = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
   endtask

   task automatic clear_lexer();
      mode = MODE_IDLE;
      position = 0;
      tok_start = 0;
      tok_len = 0;
      acc = 0;
      neg = 0;
      stopped = 0;
      point = 0;
   endtask

   task automatic add_num(logic [7:0] c);
      if (c == ".") begin
         point = 1;
         stopped = 1;
      end else if (c == "+" || c == "-") begin
         if (tok_len == 0) neg = (c == "-");
         else stopped = 1;
      end else if (!stopped) begin
         acc = acc * 10 + 32'(c - "0");
      end
      tok_len++;
   endtask

   task automatic close_token();
      case (mode)
         MODE_NUM: begin
            if (point) push_token(KIND_FLOAT, tok_start, tok_len, 0, 0);
            else push_token(KIND_INT, tok_start, tok_len, neg ? -acc : acc, 0);
         end
         MODE_SYM:   push_token(KIND_SYMBOL, tok_start, tok_len, 0, 0);
         MODE_QUOTE: push_token(KIND_UNTERM, tok_start, tok_len, 0, 0);
         MODE_SLASH: push_token(KIND_DELIM, tok_start, 1, 0, "/");
         default: ;
      endcase
      mode = MODE_IDLE;
   endtask

   task automatic open_token(logic [7:0] c, logic [31:0] pos);
      mode = MODE_IDLE;
      if (is_blank(c)) return;
      if (c == "/") begin
         mode = MODE_SLASH;
         tok_start = pos[19:0];
      end else if (is_num(c)) begin
         mode = MODE_NUM;
         tok_start = pos[19:0];
         tok_len = 0;
         acc = 0;
         neg = 0;
         stopped = 0;
         point = 0;
         add_num(c);
      end else if (is_alpha(c)) begin
         mode = MODE_SYM;
         tok_start = pos[19:0];
         tok_len = 1;
      end else if (c == "\"") begin
         mode = MODE_QUOTE;
         tok_start = 20'(pos + 1);
         tok_len = 0;
      end else begin
         push_token(KIND_DELIM, pos, 1, 0, c);
      end
   endtask

   task automatic predict_byte(logic [7:0] c, logic fin);
      logic [31:0] pos;
      pos = position;
      byte_tokens.delete();
      if (pos < BufferBytes) begin
         case (mode)
            MODE_NUM: begin
               if (is_num(c)) add_num(c);
               else begin close_token(); open_token(c, pos); end
            end
            MODE_SYM: begin
               if (is_alpha(c)) tok_len++;
               else begin close_token(); open_token(c, pos); end
            end
            MODE_QUOTE: begin
               if (c == "\"") begin
                  push_token(KIND_SYMBOL, tok_start, tok_len, 0, 0);
                  mode = MODE_IDLE;
               end else tok_len++;
            end
            MODE_SLASH: begin
               if (c == "/") mode = MODE_COMMENT;
               else begin close_token(); open_token(c, pos); end
            end
            MODE_COMMENT: if (c == 8'h0d || c == 8'h0a) mode = MODE_IDLE;
            default: open_token(c, pos);
         endcase
         position = pos + 1;
      end
      if (fin) begin
         close_token();
         push_token(KIND_END, 0, position, 0, 0);
         clear_lexer();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
      foreach (byte_tokens[i]) token_queue.insert(token_queue.size(), byte_tokens[i]);
   endtask

   always @(posedge clock) begin
      token_type want;
      token_type got;
      if (reset) begin
         clear_lexer();
         token_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_token_kind, rsp_token_start, rsp_token_length, rsp_int_value,
                   rsp_delim_char, rsp_run_end};
            if (token_queue.size() == 0) begin
               $display("%0t: unexpected item %h", $time, got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = token_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: expected kind %0d start %0d len %0d int %0d delim %h end %b",
                           $time, want.kind, want.start, want.length, $signed(want.ival),
                           want.delim, want.last);
                  $display("%0t: actual   kind %0d start %0d len %0d int %0d delim %h end %b",
                           $time, got.kind, got.start, got.length, $signed(got.ival),
                           got.delim, got.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_byte(req_byte_in, req_final_byte);
      end
      tokens_pending <= token_queue.size();
   end

endmodule

>>> test/script_byte_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Script byte tokenizer test
// Sends directed and random script text with random gaps on the request channel
// and random stalls on the response channel; the checker predicts and compares every token item.
// ----------------------------------------------------------------------------
module script_byte_tokenizer_test;

   import sbt_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 0;
   logic        req_final_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_token_kind;
   logic [19:0] rsp_token_start;
   logic [20:0] rsp_token_length;
   logic [31:0] rsp_int_value;
   logic [7:0]  rsp_delim_char;
   logic        rsp_run_end;
   int          mismatch_count;
   int          tokens_pending;
   bit          quiet_phase = 0;
   byte         text[$];
   byte         flags[$];

   script_byte_tokenizer dut (.*);

   script_byte_tokenizer_checker checker_unit (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (quiet_phase) rsp_stall <= 0;
      else if ($urandom_range(0, 14) == 0) begin
         rsp_stall <= 1;
         repeat ($urandom_range(1, 9)) @(negedge clock);
         rsp_stall <= 0;
      end
   end

   task automatic queue_text(string s, bit fin);
      foreach (s[i]) begin
         text.insert(text.size(), s[i]);
         flags.insert(flags.size(), fin && i == s.len() - 1);
      end
   endtask

   task automatic send_byte(logic [7:0] b, logic fin);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1;
      req_byte_in <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic string random_piece();
      string p;
      int n;
      p = "";
      case ($urandom_range(0, 9))
         0, 1: begin
            if ($urandom_range(0, 2) == 0) p = $urandom_range(0, 1) ? "-" : "+";
            n = $urandom_range(1, 12);
            repeat (n) p = {p, string'(8'("0" + $urandom_range(0, 9)))};
            if ($urandom_range(0, 3) == 0) p = {p, ".5"};
         end
         2, 3: begin
            n = $urandom_range(1, 6);
            repeat (n) p = {p, string'(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                         : "_"))};
         end
         4: p = "\"q x\"";
         5: p = "// note\n";
         6: p = {" ", string'(8'($urandom_range(0, 1) ? 8'h09 : 8'h0d)), "\n"};
         7: p = "/";
         default: p = string'(8'($urandom_range(1, 255)));
      endcase
      return p;
   endfunction

   initial begin
      string s;
      int sent;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      queue_text("x", 1);
      queue_text("+123 -45 +-7 - 2147483648 4294967297 1.5 3+4 ", 0);
      queue_text("ab_Z9 \"hi\" \"\" , ; / // c\r/ /", 1);
      queue_text("name", 1);
      queue_text("\"open", 1);
      queue_text("/", 1);
      queue_text("12", 1);
      while (text.size() > 0) send_byte(text.pop_front(), flags.pop_front());
      sent = 0;
      while (sent < 340) begin
         s = ($urandom_range(0, 5) == 0) ? string'(8'($urandom_range(0, 255)))
                                          : random_piece();
         foreach (s[i]) begin
            quiet_phase = sent > 290;
            send_byte(s[i], (i == s.len() - 1) && $urandom_range(0, 30) == 0);
            sent++;
         end
      end
      send_byte(8'hff, 1);
      send_byte(8'h00, 1);
      req_valid <= 0;
      while (tokens_pending > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && tokens_pending == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
